>>> rtl/core/lru_cache_miss_counter_top_macros.svh
// assertion macros shared by the lru cache miss counter rtl
`ifndef LRU_CACHE_MISS_COUNTER_TOP_MACROS_SVH
`define LRU_CACHE_MISS_COUNTER_TOP_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define LCMC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lcmc assertion failed");
// condition must never be seen at a clock edge out of reset
`define LCMC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("lcmc forbidden condition seen");
`else
`define LCMC_ASSERT(lbl, clk, rstn, prop)
`define LCMC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> rtl/core/lcmc_pkg.sv
// shared constants and types of the lru cache miss counter
package lcmc_pkg;

  // default sizes
  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned ADDR_BITS_DEF   = 24;

  // fixed field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned FIELD_W  = 24;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned MISS_W   = 32;

  // cache size after reset
  localparam logic [CFG_W-1:0] CACHE_SIZE_RST = 7'd64;

  // opcodes
  localparam logic [OP_W-1:0] OP_ADDR  = 2'd0;
  localparam logic [OP_W-1:0] OP_RANGE = 2'd1;
  localparam logic [OP_W-1:0] OP_STAT  = 2'd2;

  // flags from the shared compare unit
  typedef struct packed {
    logic tag_eq;
    logic age_ge;
  } lcmc_cmp_t;

  // miss report from the sequencer to the output register
  typedef struct packed {
    logic              valid;
    logic [MISS_W-1:0] count;
  } lcmc_stat_t;

endpackage

>>> rtl/core/lcmc_store.sv
// tag and age memories, one write and one registered read each
module lcmc_store #(
  parameter int unsigned DEPTH = lcmc_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned TAG_W = lcmc_pkg::ADDR_BITS_DEF,
  parameter int unsigned IDX_W = 6
) (
  input  logic             clk_i,
  input  logic             tag_we_i,
  input  logic [IDX_W-1:0] tag_waddr_i,
  input  logic [TAG_W-1:0] tag_wdata_i,
  input  logic             age_we_i,
  input  logic [IDX_W-1:0] age_waddr_i,
  input  logic [IDX_W-1:0] age_wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [TAG_W-1:0] rd_tag_o,
  output logic [IDX_W-1:0] rd_age_o
);
  import lcmc_pkg::*;

  logic [TAG_W-1:0] tag_mem [DEPTH];
  logic [IDX_W-1:0] age_mem [DEPTH];
  logic [TAG_W-1:0] rd_tag_q;
  logic [IDX_W-1:0] rd_age_q;

  // tag array
  always_ff @(posedge clk_i) begin
    if (tag_we_i) begin
      tag_mem[tag_waddr_i] <= tag_wdata_i;
    end
    rd_tag_q <= tag_mem[raddr_i];
  end

  // age array
  always_ff @(posedge clk_i) begin
    if (age_we_i) begin
      age_mem[age_waddr_i] <= age_wdata_i;
    end
    rd_age_q <= age_mem[raddr_i];
  end

  assign rd_tag_o = rd_tag_q;
  assign rd_age_o = rd_age_q;

endmodule

>>> rtl/core/lcmc_age_unit.sv
// shared compare unit: tag match, age compare and age increment
module lcmc_age_unit #(
  parameter int unsigned TAG_W = lcmc_pkg::ADDR_BITS_DEF,
  parameter int unsigned AGE_W = 6
) (
  input  logic [TAG_W-1:0]    rd_tag_i,
  input  logic [TAG_W-1:0]    probe_tag_i,
  input  logic [AGE_W-1:0]    rd_age_i,
  input  logic [AGE_W-1:0]    ref_age_i,
  output lcmc_pkg::lcmc_cmp_t cmp_o,
  output logic [AGE_W-1:0]    age_inc_o
);
  import lcmc_pkg::*;

  // one equality, one magnitude compare, one incrementer
  always_comb begin
    cmp_o.tag_eq = (rd_tag_i == probe_tag_i);
    cmp_o.age_ge = (rd_age_i >= ref_age_i);
    age_inc_o    = rd_age_i + AGE_W'(1);
  end

endmodule

>>> rtl/core/lcmc_seq.sv
// access sequencer: scan and update passes over the stored entries, and miss count reports
`include "lru_cache_miss_counter_top_macros.svh"
module lcmc_seq #(
  parameter int unsigned MAX_ENTRIES = lcmc_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned ADDR_BITS   = lcmc_pkg::ADDR_BITS_DEF,
  parameter int unsigned OCC_W       = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lcmc_pkg::OP_W-1:0]    opcode_i,
  input  logic [lcmc_pkg::FIELD_W-1:0] address_i,
  input  logic [lcmc_pkg::FIELD_W-1:0] stride_i,
  input  logic [lcmc_pkg::CNT_W-1:0]   count_i,
  input  logic [OCC_W-1:0]             eff_size_i,
  input  logic                         out_free_i,
  output lcmc_pkg::lcmc_stat_t         stat_o
);
  import lcmc_pkg::*;

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned EXT_W = (ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_STAT   = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [ADDR_BITS-1:0] cur_q, cur_d;
  logic [ADDR_BITS-1:0] stride_q, stride_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [OCC_W-1:0]     occ_q, occ_d;
  logic [MISS_W-1:0]    misses_q, misses_d;
  logic [OCC_W-1:0]     issue_q, issue_d;
  logic                 pv_q, pv_d;
  logic [IDX_W-1:0]     pidx_q, pidx_d;
  logic                 hit_q, hit_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]     hit_age_q, hit_age_d;
  logic [IDX_W-1:0]     max_q, max_d;
  logic [IDX_W-1:0]     victim_q, victim_d;
  logic [IDX_W-1:0]     thr_q, thr_d;
  logic [IDX_W-1:0]     tgt_q, tgt_d;
  logic                 inc_all_q, inc_all_d;

  logic [EXT_W-1:0]     base_ext;
  logic [EXT_W-1:0]     stride_ext;
  logic                 tag_we;
  logic                 age_we;
  logic [IDX_W-1:0]     age_wdata;
  logic [IDX_W-1:0]     raddr;
  logic [ADDR_BITS-1:0] rd_tag;
  logic [IDX_W-1:0]     rd_age;
  logic [IDX_W-1:0]     ref_age;
  lcmc_cmp_t            cmp;
  logic [IDX_W-1:0]     age_inc;
  logic                 issue_more;

  assign base_ext   = EXT_W'(address_i);
  assign stride_ext = EXT_W'(stride_i);
  assign issue_more = (issue_q < occ_q);
  assign raddr      = issue_q[IDX_W-1:0];
  assign ref_age    = (state_q == ST_SCAN) ? max_q : thr_q;

  // tag and age storage
  lcmc_store #(
    .DEPTH (MAX_ENTRIES),
    .TAG_W (ADDR_BITS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i       (clk_i),
    .tag_we_i    (tag_we),
    .tag_waddr_i (tgt_d),
    .tag_wdata_i (cur_q),
    .age_we_i    (age_we),
    .age_waddr_i (pidx_q),
    .age_wdata_i (age_wdata),
    .raddr_i     (raddr),
    .rd_tag_o    (rd_tag),
    .rd_age_o    (rd_age)
  );

  // compare unit shared by the scan and update passes
  lcmc_age_unit #(
    .TAG_W (ADDR_BITS),
    .AGE_W (IDX_W)
  ) u_age_unit (
    .rd_tag_i    (rd_tag),
    .probe_tag_i (cur_q),
    .rd_age_i    (rd_age),
    .ref_age_i   (ref_age),
    .cmp_o       (cmp),
    .age_inc_o   (age_inc)
  );

  // new age of the entry read back during the update pass
  always_comb begin
    if (pidx_q == tgt_q) begin
      age_wdata = '0;
    end else if (inc_all_q || !cmp.age_ge) begin
      age_wdata = age_inc;
    end else begin
      age_wdata = rd_age;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    stride_d  = stride_q;
    rem_d     = rem_q;
    occ_d     = occ_q;
    misses_d  = misses_q;
    issue_d   = issue_q;
    pv_d      = 1'b0;
    pidx_d    = pidx_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    hit_age_d = hit_age_q;
    max_d     = max_q;
    victim_d  = victim_q;
    thr_d     = thr_q;
    tgt_d     = tgt_q;
    inc_all_d = inc_all_q;
    tag_we    = 1'b0;
    age_we    = 1'b0;
    in_ready_o   = 1'b0;
    stat_o.valid = 1'b0;
    stat_o.count = misses_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cur_d    = base_ext[ADDR_BITS-1:0];
          stride_d = stride_ext[ADDR_BITS-1:0];
          unique case (opcode_i)
            OP_ADDR: begin
              rem_d   = CNT_W'(1);
              state_d = ST_START;
            end
            OP_RANGE: begin
              rem_d   = count_i;
              state_d = (count_i == '0) ? ST_IDLE : ST_START;
            end
            OP_STAT: begin
              state_d = ST_STAT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_START: begin
        issue_d  = '0;
        hit_d    = 1'b0;
        max_d    = '0;
        victim_d = '0;
        state_d  = ST_SCAN;
      end

      ST_SCAN: begin
        // issue the next read
        if (issue_more) begin
          issue_d = issue_q + OCC_W'(1);
          pv_d    = 1'b1;
          pidx_d  = issue_q[IDX_W-1:0];
        end
        // check the entry read last cycle
        if (pv_q) begin
          if (cmp.tag_eq && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = pidx_q;
            hit_age_d = rd_age;
          end
          if (cmp.age_ge) begin
            max_d    = rd_age;
            victim_d = pidx_q;
          end
        end
        if (!issue_more && !pv_q) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        issue_d = '0;
        if (hit_q) begin
          thr_d     = hit_age_q;
          tgt_d     = hit_idx_q;
          inc_all_d = 1'b0;
        end else begin
          tag_we = 1'b1;
          if (misses_q != '1) begin
            misses_d = misses_q + MISS_W'(1);
          end
          if (occ_q < eff_size_i) begin
            // free slot: all ages move up, new entry at the end
            tgt_d     = occ_q[IDX_W-1:0];
            inc_all_d = 1'b1;
            occ_d     = occ_q + OCC_W'(1);
          end else begin
            // replace the least recently used entry
            thr_d     = max_q;
            tgt_d     = victim_q;
            inc_all_d = 1'b0;
          end
        end
        state_d = ST_UPDATE;
      end

      ST_UPDATE: begin
        if (issue_more) begin
          issue_d = issue_q + OCC_W'(1);
          pv_d    = 1'b1;
          pidx_d  = issue_q[IDX_W-1:0];
        end
        if (pv_q) begin
          age_we = 1'b1;
        end
        if (!issue_more && !pv_q) begin
          if (rem_q > CNT_W'(1)) begin
            rem_d   = rem_q - CNT_W'(1);
            cur_d   = cur_q + stride_q;
            state_d = ST_START;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_STAT: begin
        stat_o.valid = 1'b1;
        if (out_free_i) begin
          misses_d = '0;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rem_q     <= '0;
      occ_q     <= '0;
      misses_q  <= '0;
      issue_q   <= '0;
      pv_q      <= 1'b0;
      hit_q     <= 1'b0;
      inc_all_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rem_q     <= rem_d;
      occ_q     <= occ_d;
      misses_q  <= misses_d;
      issue_q   <= issue_d;
      pv_q      <= pv_d;
      hit_q     <= hit_d;
      inc_all_q <= inc_all_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    stride_q  <= stride_d;
    pidx_q    <= pidx_d;
    hit_idx_q <= hit_idx_d;
    hit_age_q <= hit_age_d;
    max_q     <= max_d;
    victim_q  <= victim_d;
    thr_q     <= thr_d;
    tgt_q     <= tgt_d;
  end

  // checks
  `LCMC_ASSERT_NEVER(a_occ_bound, clk_i, rst_ni, occ_q > OCC_W'(MAX_ENTRIES))
  `LCMC_ASSERT(a_occ_only_on_decide, clk_i, rst_ni, (state_q != ST_DECIDE) |=> $stable(occ_q))
  `LCMC_ASSERT_NEVER(a_age_in_range, clk_i, rst_ni, age_we && (OCC_W'(age_wdata) >= occ_q))
  `LCMC_ASSERT(a_miss_monotone, clk_i, rst_ni, (state_q != ST_STAT) |=> (misses_q >= $past(misses_q)))

endmodule

>>> rtl/core/lru_cache_miss_counter_top.sv
// top level of the lru cache miss counter: config, sequencer, result register
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   opcode_i address_i stride_i count_i
//   out       output     out_valid_o / out_ready_i miss_count_o
//   cfg       input      cfg_we_i                  cfg_data_i (cache size)
//
// after the accept cycle one access runs a scan pass and an age update pass, each reading
// one entry per cycle from the tag and age memories and then draining the read; when a miss
// fills a free slot the update pass also covers the new entry. a range item takes count
// accesses back to back; a stat item waits until the result register is free. reset
// empties the cache, clears the miss count and sets the cache size to 64; no clearing
// pass is needed. in_ready_o is high only while the sequencer is idle.
module lru_cache_miss_counter_top #(
  parameter int unsigned MAX_ENTRIES = lcmc_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned ADDR_BITS   = lcmc_pkg::ADDR_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lcmc_pkg::OP_W-1:0]    opcode_i,
  input  logic [lcmc_pkg::FIELD_W-1:0] address_i,
  input  logic [lcmc_pkg::FIELD_W-1:0] stride_i,
  input  logic [lcmc_pkg::CNT_W-1:0]   count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lcmc_pkg::MISS_W-1:0]  miss_count_o,
  input  logic                         cfg_we_i,
  input  logic [lcmc_pkg::CFG_W-1:0]   cfg_data_i
);
  import lcmc_pkg::*;

  localparam int unsigned OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_ENTRIES);

  logic [CFG_W-1:0]  cache_size_q;
  logic [CMP_W-1:0]  size_ext;
  logic [CMP_W-1:0]  eff_ext;
  logic [OCC_W-1:0]  eff_size;
  logic              out_valid_q, out_valid_d;
  logic [MISS_W-1:0] miss_count_q, miss_count_d;
  logic              out_free;
  lcmc_stat_t        stat;

  // cache size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_size_q <= CACHE_SIZE_RST;
    end else if (cfg_we_i) begin
      cache_size_q <= cfg_data_i;
    end
  end

  // clamp the size to 1 .. MAX_ENTRIES
  always_comb begin
    size_ext = CMP_W'(cache_size_q);
    if (size_ext == '0) begin
      eff_ext = CMP_W'(1);
    end else if (size_ext > MAX_EXT) begin
      eff_ext = MAX_EXT;
    end else begin
      eff_ext = size_ext;
    end
    eff_size = eff_ext[OCC_W-1:0];
  end

  lcmc_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDR_BITS   (ADDR_BITS),
    .OCC_W       (OCC_W)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .address_i  (address_i),
    .stride_i   (stride_i),
    .count_i    (count_i),
    .eff_size_i (eff_size),
    .out_free_i (out_free),
    .stat_o     (stat)
  );

  // result register
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    miss_count_d = miss_count_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (stat.valid && out_free) begin
      out_valid_d  = 1'b1;
      miss_count_d = stat.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    miss_count_q <= miss_count_d;
  end

  assign out_valid_o  = out_valid_q;
  assign miss_count_o = miss_count_q;

endmodule
